// ===== rtl/core/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared codes and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int MODE_BITS     = 2;
    localparam int COLOR_BITS    = 24;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 24;
    localparam int IDX_BITS      = 3;

    typedef logic [MODE_BITS-1:0] t_mode;
    typedef logic [IDX_BITS-1:0]  t_idx;

    localparam t_mode MODE_OUTLINE = 2'd0;
    localparam t_mode MODE_FILL    = 2'd1;
    localparam t_mode MODE_ARC     = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_MODE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_COLOR = 1'd1;

    localparam t_mode                 MODE_RESET  = MODE_FILL;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'h00FF00;

    localparam t_idx LAST_IDX_ARC  = 3'd1;
    localparam t_idx LAST_IDX_FULL = 3'd7;

    localparam int DEC_INIT      = 3;
    localparam int DEC_STEP_DIAG = 10;
    localparam int DEC_STEP_AXIS = 6;

endpackage

// ===== rtl/core/mcr_octant.sv =====
// ----------------------------------------------------------------------------
// mcr_octant
// Maps a walk point and an octant index to one pixel position around the
// centre, wrapped to the pixel width.
// ----------------------------------------------------------------------------
module mcr_octant #(
    parameter int COORD_BITS  = 9,
    parameter int RADIUS_BITS = 8
) (
    input  logic [mcr_pkg::IDX_BITS-1:0] i_idx,
    input  logic [RADIUS_BITS-1:0]       i_step_x,
    input  logic [RADIUS_BITS-1:0]       i_step_y,
    input  logic [COORD_BITS-1:0]        i_centre_x,
    input  logic [COORD_BITS-1:0]        i_centre_y,
    output logic signed [COORD_BITS+1:0] o_pixel_x,
    output logic signed [COORD_BITS+1:0] o_pixel_y
);

    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int SUM_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    logic [RADIUS_BITS-1:0] w_a;
    logic [RADIUS_BITS-1:0] w_b;
    logic                   w_neg_a;
    logic                   w_neg_b;
    logic [SUM_BITS-1:0]    w_dx;
    logic [SUM_BITS-1:0]    w_dy;
    logic [SUM_BITS-1:0]    w_px;
    logic [SUM_BITS-1:0]    w_py;

    always_comb begin
        w_a     = i_idx[2] ? i_step_y : i_step_x;
        w_b     = i_idx[2] ? i_step_x : i_step_y;
        w_neg_a = i_idx[0] ^ i_idx[1];
        w_neg_b = i_idx[1];
        w_dx    = w_neg_a ? (SUM_BITS'(0) - SUM_BITS'(w_a)) : SUM_BITS'(w_a);
        w_dy    = w_neg_b ? (SUM_BITS'(0) - SUM_BITS'(w_b)) : SUM_BITS'(w_b);
        w_px    = SUM_BITS'(i_centre_x) + w_dx;
        w_py    = SUM_BITS'(i_centre_y) + w_dy;
    end

    assign o_pixel_x = signed'(w_px[PIX_BITS-1:0]);
    assign o_pixel_y = signed'(w_py[PIX_BITS-1:0]);

endmodule

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle walk with outline, filled disc and lower arc drawing.
// ----------------------------------------------------------------------------
// A start request gives no pixels. A step request while a drawing is in
// progress gives eight pixels in outline and filled mode and two in arc mode,
// one per cycle while the output is not stalled. The walk state advances in
// the cycle the step request is accepted, and the next request is taken in
// the cycle its last pixel moves to the output register, so steps follow
// each other without gaps.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = 9,
    parameter int RADIUS_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [COORD_BITS-1:0]                i_center_x,
    input  logic [COORD_BITS-1:0]                i_center_y,
    input  logic [RADIUS_BITS-1:0]               i_radius,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [COORD_BITS+1:0]         o_pixel_x,
    output logic signed [COORD_BITS+1:0]         o_pixel_y,
    output logic [mcr_pkg::COLOR_BITS-1:0]       o_pixel_color,
    output logic                                 o_last_of_step,
    output logic                                 o_drawing_done,
    input  logic                                 i_cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [mcr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int PIX_BITS  = COORD_BITS + 2;
    localparam int WALK_BITS = RADIUS_BITS + 2;
    localparam int DEC_BITS  = RADIUS_BITS + 4;

    mcr_pkg::t_mode                   r_draw_mode;
    logic [mcr_pkg::COLOR_BITS-1:0]   r_draw_color;

    logic                             r_busy, n_busy;
    logic [COORD_BITS-1:0]            r_centre_x, n_centre_x;
    logic [COORD_BITS-1:0]            r_centre_y, n_centre_y;
    logic [RADIUS_BITS-1:0]           r_cur_radius, n_cur_radius;
    logic [RADIUS_BITS-1:0]           r_step_x, n_step_x;
    logic [RADIUS_BITS-1:0]           r_step_y, n_step_y;
    logic signed [DEC_BITS-1:0]       r_decision, n_decision;

    logic                             r_bst_vld;
    mcr_pkg::t_idx                    r_bst_idx;
    logic [RADIUS_BITS-1:0]           r_bst_x;
    logic [RADIUS_BITS-1:0]           r_bst_y;
    logic [COORD_BITS-1:0]            r_bst_cx;
    logic [COORD_BITS-1:0]            r_bst_cy;
    logic                             r_bst_arc;
    logic                             r_bst_done;
    logic [mcr_pkg::COLOR_BITS-1:0]   r_bst_color;

    logic                             r_out_vld;
    logic signed [PIX_BITS-1:0]       r_out_x;
    logic signed [PIX_BITS-1:0]       r_out_y;
    logic [mcr_pkg::COLOR_BITS-1:0]   r_out_color;
    logic                             r_out_last;
    logic                             r_out_done;

    logic                             w_in_acc;
    logic                             w_step_emit;
    logic                             w_arc;
    logic signed [WALK_BITS-1:0]      w_x, w_nx, w_y, w_ny;
    logic signed [DEC_BITS-1:0]       w_dnx, w_dy, w_dec_init;
    logic                             w_out_free;
    logic                             w_bst_adv;
    logic                             w_bst_last;
    logic                             w_bst_end;
    logic signed [PIX_BITS-1:0]       w_pix_x;
    logic signed [PIX_BITS-1:0]       w_pix_y;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_bst_adv  = r_bst_vld && w_out_free;
    assign w_bst_last = (r_bst_idx == (r_bst_arc ? mcr_pkg::LAST_IDX_ARC
                                                 : mcr_pkg::LAST_IDX_FULL));
    assign w_bst_end  = w_bst_adv && w_bst_last;
    assign o_in_ready = !r_bst_vld || w_bst_end;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_arc      = (r_draw_mode == mcr_pkg::MODE_ARC);

    always_comb begin
        w_x        = signed'(WALK_BITS'(r_step_x));
        w_y        = signed'(WALK_BITS'(r_step_y));
        w_nx       = w_x + WALK_BITS'(1);
        w_dnx      = DEC_BITS'(w_nx);
        w_dy       = DEC_BITS'(w_y);
        w_dec_init = DEC_BITS'(mcr_pkg::DEC_INIT) - (DEC_BITS'(i_radius) <<< 1);

        n_busy       = r_busy;
        n_centre_x   = r_centre_x;
        n_centre_y   = r_centre_y;
        n_cur_radius = r_cur_radius;
        n_step_x     = r_step_x;
        n_step_y     = r_step_y;
        n_decision   = r_decision;
        w_ny         = w_y;
        w_step_emit  = 1'b0;

        if (w_in_acc) begin
            if (i_operation == mcr_pkg::OP_START) begin
                n_centre_x   = i_center_x;
                n_centre_y   = i_center_y;
                n_cur_radius = i_radius;
                n_step_x     = '0;
                n_step_y     = i_radius;
                n_decision   = w_dec_init;
                n_busy       = (i_radius != '0) || w_arc;
            end else if (r_busy) begin
                w_step_emit = 1'b1;
                n_step_x    = w_nx[RADIUS_BITS-1:0];
                if (r_decision > 0) begin
                    n_decision = r_decision + ((w_dnx - w_dy) <<< 2)
                               + DEC_BITS'(mcr_pkg::DEC_STEP_DIAG);
                    w_ny       = w_y - WALK_BITS'(1);
                end else begin
                    n_decision = r_decision + (w_dnx <<< 2)
                               + DEC_BITS'(mcr_pkg::DEC_STEP_AXIS);
                end
                n_step_y = w_ny[RADIUS_BITS-1:0];
                if (w_nx > w_ny) begin
                    if ((r_draw_mode == mcr_pkg::MODE_FILL) &&
                        (r_cur_radius > RADIUS_BITS'(1))) begin
                        n_cur_radius = r_cur_radius - RADIUS_BITS'(1);
                        n_step_x     = '0;
                        n_step_y     = r_cur_radius - RADIUS_BITS'(1);
                        n_decision   = DEC_BITS'(mcr_pkg::DEC_INIT)
                                     - (DEC_BITS'(r_cur_radius - RADIUS_BITS'(1)) <<< 1);
                    end else begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode  <= mcr_pkg::MODE_RESET;
            r_draw_color <= mcr_pkg::COLOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcr_pkg::REG_DRAW_MODE: begin
                    r_draw_mode <= i_cfg_data[mcr_pkg::MODE_BITS-1:0];
                end
                mcr_pkg::REG_DRAW_COLOR: begin
                    r_draw_color <= i_cfg_data[mcr_pkg::COLOR_BITS-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_centre_x   <= n_centre_x;
        r_centre_y   <= n_centre_y;
        r_cur_radius <= n_cur_radius;
        r_step_x     <= n_step_x;
        r_step_y     <= n_step_y;
        r_decision   <= n_decision;
    end

    // hold the current point until all its pixels have moved out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst_vld <= 1'b0;
            r_bst_idx <= '0;
        end else begin
            priority if (w_step_emit) begin
                r_bst_vld <= 1'b1;
                r_bst_idx <= '0;
            end else if (w_bst_end) begin
                r_bst_vld <= 1'b0;
            end else if (w_bst_adv) begin
                r_bst_idx <= r_bst_idx + mcr_pkg::IDX_BITS'(1);
            end
        end
        if (w_step_emit) begin
            r_bst_x     <= r_step_x;
            r_bst_y     <= r_step_y;
            r_bst_cx    <= r_centre_x;
            r_bst_cy    <= r_centre_y;
            r_bst_arc   <= w_arc;
            r_bst_done  <= !n_busy;
            r_bst_color <= r_draw_color;
        end
    end

    mcr_octant #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_octant (
        .i_idx      (r_bst_idx),
        .i_step_x   (r_bst_x),
        .i_step_y   (r_bst_y),
        .i_centre_x (r_bst_cx),
        .i_centre_y (r_bst_cy),
        .o_pixel_x  (w_pix_x),
        .o_pixel_y  (w_pix_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_bst_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_bst_adv) begin
            r_out_x     <= w_pix_x;
            r_out_y     <= w_pix_y;
            r_out_color <= r_bst_color;
            r_out_last  <= w_bst_last;
            r_out_done  <= w_bst_last && r_bst_done;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_color  = r_out_color;
    assign o_last_of_step = r_out_last;
    assign o_drawing_done = r_out_done;

endmodule

// ===== rtl/core/mcr_checker.sv =====
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks of the midpoint circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker #(
    parameter int COORD_BITS = 9
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_BITS+1:0]  o_pixel_x,
    input logic signed [COORD_BITS+1:0]  o_pixel_y,
    input logic                          o_last_of_step,
    input logic                          o_drawing_done
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drawing_done |-> o_last_of_step)
        else $error("drawing end flagged off a step end");

    a_step_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_step |=> o_out_valid)
        else $error("gap inside a step request");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y))
        else $error("stalled pixel changed");

endmodule

bind midpoint_circle_rasterizer mcr_checker #(
    .COORD_BITS (COORD_BITS)
) u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_last_of_step (o_last_of_step),
    .o_drawing_done (o_drawing_done)
);
